>>> sv/llns_pkg.sv
// ----------------------------------------------------------------------------
// llns_pkg
// Shared types and codes for the least loaded node selector: request and
// response payloads, the scan token that moves along the slot chain, and
// the broadcast and update bundles that drive every slot cell.
// ----------------------------------------------------------------------------
`default_nettype none

package llns_pkg;

    localparam int LOAD_W = 31;
    localparam int ID_W   = 16;
    localparam int COST_W = 16;
    localparam int TYPE_W = 4;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CHOOSE = 2'd1;
    localparam logic [1:0] CMD_COST   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Response status codes
    localparam logic [2:0] STAT_CHOSEN  = 3'd0;
    localparam logic [2:0] STAT_NONE    = 3'd1;
    localparam logic [2:0] STAT_ADDED   = 3'd2;
    localparam logic [2:0] STAT_PRESENT = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;
    localparam logic [2:0] STAT_COST    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } llns_state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   node_id;
        logic [TYPE_W-1:0] node_type;
        logic [COST_W-1:0] bandwidth_cost;
        logic [COST_W-1:0] overload_cost;
    } llns_req_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] chosen_id;
        logic            chosen_valid;
    } llns_rsp_t;

    // Scan token: best candidate so far (choose) or first free slot (add)
    typedef struct packed {
        logic              found;
        logic              hit;
        logic [LOAD_W-1:0] k1;
        logic [LOAD_W-1:0] k2;
        logic [ID_W-1:0]   id;
    } llns_token_t;

    // Held for the whole scan of one request
    typedef struct packed {
        logic            is_add;
        logic            bw_first;
        logic [ID_W-1:0] match_id;
    } llns_bcast_t;

    // Slot write issued at the end of a scan
    typedef struct packed {
        logic              install;
        logic              bump;
        logic [ID_W-1:0]   new_id;
        logic [COST_W-1:0] cost_bw;
        logic [COST_W-1:0] cost_ov;
    } llns_upd_t;

endpackage

`default_nettype wire

>>> sv/llns_cell.sv
// ----------------------------------------------------------------------------
// llns_cell
// One worker slot: holds valid, id and both load counters, merges its own
// entry into the scan token from its left neighbor and registers the
// result for its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module llns_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire llns_pkg::llns_bcast_t bcast,
    input  wire llns_pkg::llns_token_t tok_in,
    input  wire logic [IDX_W-1:0]     idx_in,
    output llns_pkg::llns_token_t      tok_out,
    output logic [IDX_W-1:0]          idx_out,
    input  wire llns_pkg::llns_upd_t   upd,
    input  wire logic [IDX_W-1:0]     upd_idx
);
    import llns_pkg::*;

    logic              valid_reg;
    logic [ID_W-1:0]   id_reg;
    logic [LOAD_W-1:0] bw_reg;
    logic [LOAD_W-1:0] ov_reg;
    llns_token_t       tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic [LOAD_W-1:0] k1, k2;
    logic              take;
    logic              upd_hit;
    logic [LOAD_W:0]   bw_sum, ov_sum;
    logic [LOAD_W-1:0] bw_sat, ov_sat;

    assign k1 = bcast.bw_first ? bw_reg : ov_reg;
    assign k2 = bcast.bw_first ? ov_reg : bw_reg;
    assign take = valid_reg && (!tok_in.found || (k1 < tok_in.k1) ||
                                ((k1 == tok_in.k1) && (k2 < tok_in.k2)));

    always_comb begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (bcast.is_add) begin
            if (valid_reg && (id_reg == bcast.match_id)) begin
                tok_next.hit = 1'b1;
            end
            if (!valid_reg && !tok_in.found) begin
                tok_next.found = 1'b1;
                idx_next       = IDX_W'(INDEX);
            end
        end else if (take) begin
            tok_next.found = 1'b1;
            tok_next.k1    = k1;
            tok_next.k2    = k2;
            tok_next.id    = id_reg;
            idx_next       = IDX_W'(INDEX);
        end
    end

    // Saturate at the counter maximum
    assign bw_sum  = {1'b0, bw_reg} + (LOAD_W + 1)'(upd.cost_bw);
    assign ov_sum  = {1'b0, ov_reg} + (LOAD_W + 1)'(upd.cost_ov);
    assign bw_sat  = bw_sum[LOAD_W] ? {LOAD_W{1'b1}} : bw_sum[LOAD_W-1:0];
    assign ov_sat  = ov_sum[LOAD_W] ? {LOAD_W{1'b1}} : ov_sum[LOAD_W-1:0];
    assign upd_hit = (upd_idx == IDX_W'(INDEX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (upd.install && upd_hit) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.install && upd_hit) begin
            id_reg <= upd.new_id;
            bw_reg <= '0;
            ov_reg <= '0;
        end else if (upd.bump && upd_hit) begin
            bw_reg <= bw_sat;
            ov_reg <= ov_sat;
        end
        tok_reg <= tok_next;
        idx_reg <= idx_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

>>> sv/least_loaded_node_selector.sv
// ----------------------------------------------------------------------------
// least_loaded_node_selector
// Worker table with least-loaded selection, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each worker slot lives in its own cell, and the cells form a row. An add or
// choose request launches a scan token at the left end; every cycle each cell
// merges its slot into the token (lowest load wins, ties keep the lower slot
// already in the token) and passes it right. Once the token has crossed every
// cell, the token leaving the last cell names the winner or the first free
// slot, and a final step writes that slot back and loads the response. The
// time an add or choose takes from acceptance to response is set by the length
// of the cell chain; a cost write goes straight to that final step, and an
// unused command code is dropped in its accept cycle. One request is in
// flight at a time. The response sits in an output register, so s_ready
// returns as soon as the response is loaded, even if m_ready is low; the next
// request is taken from the next cycle on at the earliest. A response still
// waiting in the output register holds the following one in its last step.
// gate_type is written over APB at byte address 0 and selects the requests
// that rank by bandwidth first.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_node_selector #(
    parameter int WORKER_SLOTS = 16,
    parameter int NODE_TYPES   = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire llns_pkg::llns_req_t s_req,
    // response channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output llns_pkg::llns_rsp_t      m_rsp,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import llns_pkg::*;

    localparam int IDX_W      = $clog2(WORKER_SLOTS);
    localparam int COST_DEPTH = (NODE_TYPES < 16) ? NODE_TYPES : 16;
    localparam int CIDX_W     = $clog2(COST_DEPTH);

    // Configuration
    logic [TYPE_W-1:0] gate_type_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(gate_type_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_type_reg <= '0;
        end else if (cfg_wr) begin
            gate_type_reg <= pwdata[TYPE_W-1:0];
        end
    end

    // Control state
    llns_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       cmd_reg;
    llns_bcast_t      bcast_reg;
    logic [COST_W-1:0] cost_bw_reg, cost_ov_reg;
    logic             m_valid_reg, m_valid_next;
    llns_rsp_t        m_rsp_reg, m_rsp_next;

    // Cost table
    logic [COST_W-1:0] type_bw_cost_reg [COST_DEPTH];
    logic [COST_W-1:0] type_ov_cost_reg [COST_DEPTH];
    logic              type_ok;
    logic [CIDX_W-1:0] cidx;

    assign type_ok = (32'(s_req.node_type) < NODE_TYPES);
    assign cidx    = s_req.node_type[CIDX_W-1:0];

    // Cell chain
    llns_token_t      tok   [WORKER_SLOTS+1];
    logic [IDX_W-1:0] idx   [WORKER_SLOTS+1];
    llns_upd_t        upd;
    logic [IDX_W-1:0] upd_idx;

    assign tok[0] = '0;
    assign idx[0] = '0;

    for (genvar g = 0; g < WORKER_SLOTS; g++) begin : g_cell
        llns_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bcast   (bcast_reg),
            .tok_in  (tok[g]),
            .idx_in  (idx[g]),
            .tok_out (tok[g+1]),
            .idx_out (idx[g+1]),
            .upd     (upd),
            .upd_idx (upd_idx)
        );
    end

    logic accept;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        upd          = '0;
        upd_idx      = idx[WORKER_SLOTS];
        upd.new_id   = bcast_reg.match_id;
        upd.cost_bw  = cost_bw_reg;
        upd.cost_ov  = cost_ov_reg;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    case (s_req.cmd) inside
                        CMD_ADD, CMD_CHOOSE: state_next = ST_SCAN;
                        CMD_COST:            state_next = ST_DONE;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                // advance until the token has crossed every cell
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(WORKER_SLOTS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the outcome until the response register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = '0;
                    state_next   = ST_IDLE;
                    case (cmd_reg)
                        CMD_ADD: begin
                            if (tok[WORKER_SLOTS].hit) begin
                                m_rsp_next.status = STAT_PRESENT;
                            end else if (!tok[WORKER_SLOTS].found) begin
                                m_rsp_next.status = STAT_FULL;
                            end else begin
                                upd.install       = 1'b1;
                                m_rsp_next.status = STAT_ADDED;
                            end
                        end
                        CMD_CHOOSE: begin
                            if (tok[WORKER_SLOTS].found) begin
                                upd.bump                = 1'b1;
                                m_rsp_next.status       = STAT_CHOSEN;
                                m_rsp_next.chosen_id    = tok[WORKER_SLOTS].id;
                                m_rsp_next.chosen_valid = 1'b1;
                            end else begin
                                m_rsp_next.status = STAT_NONE;
                            end
                        end
                        default: begin
                            m_rsp_next.status = STAT_COST;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request; costs come from the table at acceptance
    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
        if (accept) begin
            cmd_reg            <= s_req.cmd;
            bcast_reg.is_add   <= (s_req.cmd == CMD_ADD);
            bcast_reg.bw_first <= (s_req.node_type == gate_type_reg);
            bcast_reg.match_id <= s_req.node_id;
            cost_bw_reg        <= type_ok ? type_bw_cost_reg[cidx] : '0;
            cost_ov_reg        <= type_ok ? type_ov_cost_reg[cidx] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COST_DEPTH; i++) begin
                type_bw_cost_reg[i] <= '0;
                type_ov_cost_reg[i] <= '0;
            end
        end else if (accept && (s_req.cmd == CMD_COST) && type_ok) begin
            type_bw_cost_reg[cidx] <= s_req.bandwidth_cost;
            type_ov_cost_reg[cidx] <= s_req.overload_cost;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire

>>> sv/llns_checker.sv
// ----------------------------------------------------------------------------
// llns_checker
// Port-level checks for the least loaded node selector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module llns_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire llns_pkg::llns_req_t s_req,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire llns_pkg::llns_rsp_t m_rsp
);
    import llns_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response changed while stalled");

    a_valid_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.chosen_valid == (m_rsp.status == STAT_CHOSEN)))
        else $error("chosen_valid disagrees with status");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status != STAT_CHOSEN) |-> (m_rsp.chosen_id == '0))
        else $error("chosen_id set without a chosen worker");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status <= STAT_COST))
        else $error("status code out of range");

    // One request at a time: a real command closes the request side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req.cmd != CMD_UNUSED) |=> !s_ready)
        else $error("request taken while another is in flight");

endmodule

bind least_loaded_node_selector llns_checker u_llns_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

`default_nettype wire
